### rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by rhc_div_step and rgb_to_hsv_converter.

package rhc_pkg;

    // Width of every pixel field, input and output.
    localparam int FIELD_W = 12;

    // Hue divisor is six times the chroma; 6 * 4095 fits in 15 bits.
    localparam int HUE_DEN_W = FIELD_W + 3;
    // Saturation divisor is the value itself.
    localparam int SAT_DEN_W = FIELD_W;

    // Hue sector, chosen in priority order red, green, blue.
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // Partial remainders and divisors of the two fraction dividers.
    // Both divisions have a dividend below the divisor, so each step
    // yields exactly one quotient bit.
    typedef struct packed {
        logic [HUE_DEN_W-1:0] hue_rem;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_DEN_W-1:0] sat_rem;
        logic [SAT_DEN_W-1:0] sat_den;
    } div_slot_t;

endpackage

### rtl/rhc_div_step.sv
// One restoring division step for the hue and saturation dividers.
// Depends on rhc_pkg for the divider slot type and widths.

module rhc_div_step
    import rhc_pkg::*;
(
    input  div_slot_t slot_in,
    output div_slot_t slot_out,
    output logic      hue_bit,
    output logic      sat_bit
);

    logic [HUE_DEN_W:0] hue_shift;
    logic [HUE_DEN_W:0] hue_diff;
    logic [SAT_DEN_W:0] sat_shift;
    logic [SAT_DEN_W:0] sat_diff;

    // Double the remainder and subtract the divisor when it fits.
    assign hue_shift = {slot_in.hue_rem, 1'b0};
    assign hue_diff  = hue_shift - {1'b0, slot_in.hue_den};
    assign hue_bit   = (hue_shift >= {1'b0, slot_in.hue_den});

    assign sat_shift = {slot_in.sat_rem, 1'b0};
    assign sat_diff  = sat_shift - {1'b0, slot_in.sat_den};
    assign sat_bit   = (sat_shift >= {1'b0, slot_in.sat_den});

    always_comb
    begin
        slot_out.hue_den = slot_in.hue_den;
        slot_out.sat_den = slot_in.sat_den;
        slot_out.hue_rem = hue_bit ? hue_diff[HUE_DEN_W-1:0] : hue_shift[HUE_DEN_W-1:0];
        slot_out.sat_rem = sat_bit ? sat_diff[SAT_DEN_W-1:0] : sat_shift[SAT_DEN_W-1:0];
    end

endmodule

### rtl/rgb_to_hsv_converter.sv
// Top level of the pipelined RGB to HSV pixel converter.
// Depends on rhc_pkg and rhc_div_step.
//
//  Channel | Signals                          | Direction | Transfer when
//  --------+----------------------------------+-----------+------------------------
//  pixel   | pixel_valid, red, green, blue    | in        | pixel_valid && !pixel_stall
//          | pixel_stall                      | out       |
//  hsv     | hsv_valid, hue, saturation, value| out       | hsv_valid && !hsv_stall
//          | hsv_stall                        | in        |
//
// One pixel can enter in every clock cycle while pixel_stall is low. A pixel's result
// passes through the registers for the max/min, the chroma and the hue numerator,
// then the divider registers, which produce the hue and saturation quotient bits
// together, and finally the output register.
// Reset clears only the valid bits of the pipeline; payload is not reset.
// When a result waits on hsv_stall the whole pipeline holds, and
// pixel_stall is raised in that same cycle, so nothing is lost or repeated.

module rgb_to_hsv_converter
    import rhc_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [FIELD_W-1:0] red,
    input  logic [FIELD_W-1:0] green,
    input  logic [FIELD_W-1:0] blue,
    output logic               hsv_valid,
    input  logic               hsv_stall,
    output logic [FIELD_W-1:0] hue,
    output logic [FIELD_W-1:0] saturation,
    output logic [FIELD_W-1:0] value
);

    localparam int NUM_W = HUE_DEN_W + 1;

    // The whole pipeline moves together unless a finished result is held.
    logic advance;

    assign advance     = !(hsv_valid && hsv_stall);
    assign pixel_stall = !advance;

    // ------------------------------------------------------------------
    // Stage A: maximum, minimum and sector.
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic [FIELD_W-1:0] a_r_reg, a_g_reg, a_b_reg;
    logic [FIELD_W-1:0] a_max_reg, a_min_reg;
    sector_t            a_sector_reg;
    logic [FIELD_W-1:0] a_max_next, a_min_next;
    sector_t            a_sector_next;

    always_comb
    begin
        a_max_next = red;
        if (green > a_max_next)
        begin
            a_max_next = green;
        end
        if (blue > a_max_next)
        begin
            a_max_next = blue;
        end
        a_min_next = red;
        if (green < a_min_next)
        begin
            a_min_next = green;
        end
        if (blue < a_min_next)
        begin
            a_min_next = blue;
        end
        // Ties go to the first channel in priority order.
        if (a_max_next == red)
        begin
            a_sector_next = SECT_RED;
        end
        else if (a_max_next == green)
        begin
            a_sector_next = SECT_GREEN;
        end
        else
        begin
            a_sector_next = SECT_BLUE;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: chroma and the signed channel difference of the sector.
    // ------------------------------------------------------------------
    logic                      b_valid_reg;
    logic [FIELD_W-1:0]        b_max_reg, b_chroma_reg;
    logic signed [FIELD_W:0]   b_diff_reg;
    sector_t                   b_sector_reg;
    logic [FIELD_W-1:0]        b_chroma_next;
    logic signed [FIELD_W:0]   b_diff_next;

    assign b_chroma_next = a_max_reg - a_min_reg;

    always_comb
    begin
        case (a_sector_reg)
            SECT_RED:
            begin
                b_diff_next = $signed({1'b0, a_g_reg}) - $signed({1'b0, a_b_reg});
            end
            SECT_GREEN:
            begin
                b_diff_next = $signed({1'b0, a_b_reg}) - $signed({1'b0, a_r_reg});
            end
            SECT_BLUE:
            begin
                b_diff_next = $signed({1'b0, a_r_reg}) - $signed({1'b0, a_g_reg});
            end
            default:
            begin
                b_diff_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage C: hue numerator wrapped into [0, 6C), divider operands.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]        c_two_c, c_four_c, c_six_c, c_base;
    logic signed [NUM_W-1:0] c_num_raw, c_num;
    div_slot_t               c_slot_next;
    logic                    c_full_next;

    assign c_two_c  = {{(NUM_W-FIELD_W-1){1'b0}}, b_chroma_reg, 1'b0};
    assign c_four_c = {{(NUM_W-FIELD_W-2){1'b0}}, b_chroma_reg, 2'b00};
    assign c_six_c  = c_two_c + c_four_c;

    always_comb
    begin
        case (b_sector_reg)
            SECT_RED:   c_base = '0;
            SECT_GREEN: c_base = c_two_c;
            SECT_BLUE:  c_base = c_four_c;
            default:    c_base = '0;
        endcase
        c_num_raw = $signed(c_base) + NUM_W'(b_diff_reg);
        // Only a negative red-sector difference can land below zero.
        if (c_num_raw < 0)
        begin
            c_num = c_num_raw + $signed(c_six_c);
        end
        else
        begin
            c_num = c_num_raw;
        end

        // Gray pixels divide zero by one, giving a hue of zero.
        c_slot_next.hue_rem = c_num[HUE_DEN_W-1:0];
        if (b_chroma_reg == '0)
        begin
            c_slot_next.hue_den = HUE_DEN_W'(1);
        end
        else
        begin
            c_slot_next.hue_den = c_six_c[HUE_DEN_W-1:0];
        end

        // Chroma equal to value saturates (or is black, handled by a zero
        // value); both run a zero-over-one division and use the flag.
        c_full_next = (b_chroma_reg == b_max_reg) && (b_max_reg != '0);
        if (b_chroma_reg == b_max_reg)
        begin
            c_slot_next.sat_rem = '0;
            c_slot_next.sat_den = SAT_DEN_W'(1);
        end
        else
        begin
            c_slot_next.sat_rem = b_chroma_reg;
            c_slot_next.sat_den = b_max_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline: index 0 holds the operands, index k holds the
    // state after k quotient bits.
    // ------------------------------------------------------------------
    logic                 d_valid_reg [0:FRAC_BITS];
    div_slot_t            d_slot_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] d_hue_q_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] d_sat_q_reg [0:FRAC_BITS];
    logic [FIELD_W-1:0]   d_max_reg   [0:FRAC_BITS];
    logic                 d_full_reg  [0:FRAC_BITS];

    // Stages A, B and the divider entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            d_valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg    <= pixel_valid;
            b_valid_reg    <= a_valid_reg;
            d_valid_reg[0] <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_r_reg        <= red;
            a_g_reg        <= green;
            a_b_reg        <= blue;
            a_max_reg      <= a_max_next;
            a_min_reg      <= a_min_next;
            a_sector_reg   <= a_sector_next;
            b_max_reg      <= a_max_reg;
            b_chroma_reg   <= b_chroma_next;
            b_diff_reg     <= b_diff_next;
            b_sector_reg   <= a_sector_reg;
            d_slot_reg[0]  <= c_slot_next;
            d_hue_q_reg[0] <= '0;
            d_sat_q_reg[0] <= '0;
            d_max_reg[0]   <= b_max_reg;
            d_full_reg[0]  <= c_full_next;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_div
        div_slot_t slot_next;
        logic      hue_bit;
        logic      sat_bit;

        rhc_div_step u_step (
            .slot_in  (d_slot_reg[k-1]),
            .slot_out (slot_next),
            .hue_bit  (hue_bit),
            .sat_bit  (sat_bit)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                d_slot_reg[k]  <= slot_next;
                d_hue_q_reg[k] <= {d_hue_q_reg[k-1][FRAC_BITS-2:0], hue_bit};
                d_sat_q_reg[k] <= {d_sat_q_reg[k-1][FRAC_BITS-2:0], sat_bit};
                d_max_reg[k]   <= d_max_reg[k-1];
                d_full_reg[k]  <= d_full_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate and fit the quotients to the field width.
    // ------------------------------------------------------------------
    logic                         hsv_valid_reg;
    logic [FIELD_W-1:0]           hue_reg, saturation_reg, value_reg;
    logic [FRAC_BITS-1:0]         sat_q;
    logic [FRAC_BITS+FIELD_W-1:0] hue_ext, sat_ext;

    assign sat_q   = d_full_reg[FRAC_BITS] ? {FRAC_BITS{1'b1}} : d_sat_q_reg[FRAC_BITS];
    assign hue_ext = {{FIELD_W{1'b0}}, d_hue_q_reg[FRAC_BITS]};
    assign sat_ext = {{FIELD_W{1'b0}}, sat_q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            hsv_valid_reg <= d_valid_reg[FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg        <= hue_ext[FIELD_W-1:0];
            saturation_reg <= sat_ext[FIELD_W-1:0];
            value_reg      <= d_max_reg[FRAC_BITS];
        end
    end

    assign hsv_valid  = hsv_valid_reg;
    assign hue        = hue_reg;
    assign saturation = saturation_reg;
    assign value      = value_reg;

endmodule

### sim/tb_rgb_to_hsv_converter.sv
// Self-checking testbench for rgb_to_hsv_converter: drives pixels, predicts HSV results.
// Depends on rhc_pkg (field width, sector enum) and the converter RTL; needs nothing else.

module tb_rgb_to_hsv_converter
    import rhc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The converter is built with its default precision, so a code x means x / 4096.
    localparam int      FRAC_BITS    = 12;
    localparam longint  ONE_CODE     = longint'(1) << FRAC_BITS;
    localparam int      LATENCY      = FRAC_BITS + 4;
    // Extra cycles after the last result, to catch anything the block emits late.
    localparam int      DRAIN_CYCLES = LATENCY + 8;
    // Length of the long output hold-off that backs the pipeline up to its input.
    localparam int      HOLD_CYCLES  = 300;
    localparam int      MAX_REPORTS  = 10;
    // Random items per idling phase; four phases plus the hold-off test.
    localparam int      PHASE_ITEMS  = 470;
    localparam int      HOLD_ITEMS   = 64;
    // Far beyond the slowest correct run.
    localparam int      WATCHDOG_NS  = 2_000_000;

    typedef struct packed {
        logic [FIELD_W-1:0] r;
        logic [FIELD_W-1:0] g;
        logic [FIELD_W-1:0] b;
    } pixel_t;

    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] sat;
        logic [FIELD_W-1:0] val;
    } hsv_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               pixel_valid = 1'b0;
    logic               pixel_stall;
    logic [FIELD_W-1:0] red         = '0;
    logic [FIELD_W-1:0] green       = '0;
    logic [FIELD_W-1:0] blue        = '0;
    logic               hsv_valid;
    logic               hsv_stall   = 1'b0;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] value;

    // Idling controls, changed by the test tasks between phases.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    // A one-cycle pulse on hold_go starts the long hold-off; hold_left counts it down.
    logic        hold_go   = 1'b0;
    int unsigned hold_left = 0;

    // Results predicted for accepted pixels, oldest first.
    hsv_t pending_hsv[$];
    int   error_count = 0;

    rgb_to_hsv_converter #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hue         (hue),
        .saturation  (saturation),
        .value       (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fixed-point HSV of one pixel. Value is the largest channel and chroma
    // is value minus the smallest one. Saturation is chroma over value,
    // clamped to the all-ones code, and zero for a black pixel. Hue is the
    // fraction of a turn: the sector offset (0, 2 or 4 chroma units, with
    // red winning ties over green and green over blue) plus the signed
    // difference of the other two channels, wrapped into one full turn of
    // six chroma units when it comes out negative. Gray pixels get hue zero.
    function automatic hsv_t predict_hsv(input pixel_t p);
        int      r;
        int      g;
        int      b;
        int      v;
        int      lo;
        int      chroma;
        int      base;
        int      diff;
        int      num;
        longint  q;
        sector_t sect;
        hsv_t    res;

        r = p.r;
        g = p.g;
        b = p.b;
        v = r;
        if (g > v) v = g;
        if (b > v) v = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        chroma = v - lo;

        if (v == 0)
        begin
            q = 0;
        end
        else
        begin
            q = (longint'(chroma) << FRAC_BITS) / v;
            if (q > ONE_CODE - 1) q = ONE_CODE - 1;
        end
        res.sat = q[FIELD_W-1:0];

        if (chroma == 0)
        begin
            q = 0;
        end
        else
        begin
            if (v == r)
                sect = SECT_RED;
            else if (v == g)
                sect = SECT_GREEN;
            else
                sect = SECT_BLUE;
            case (sect)
                SECT_RED:
                begin
                    base = 0;
                    diff = g - b;
                end
                SECT_GREEN:
                begin
                    base = 2 * chroma;
                    diff = b - r;
                end
                default:
                begin
                    base = 4 * chroma;
                    diff = r - g;
                end
            endcase
            num = base + diff;
            if (num < 0) num += 6 * chroma;
            q = (longint'(num) << FRAC_BITS) / (6 * chroma);
        end
        res.hue = q[FIELD_W-1:0];
        res.val = v[FIELD_W-1:0];
        return res;
    endfunction

    // Random pixels in several flavors: fully random codes, the extreme codes,
    // near-gray pixels where chroma is tiny and the divisions are sharpest,
    // tied maxima that test the sector priority, and very dark pixels.
    function automatic pixel_t random_pixel();
        pixel_t      p;
        int          base;
        int          m;
        int          lo;
        int unsigned mode;

        mode = $urandom_range(5);
        case (mode)
            1:
            begin
                p.r = ($urandom_range(1) != 0) ? FIELD_W'($urandom_range(4094, 4095))
                                               : FIELD_W'($urandom_range(1));
                p.g = ($urandom_range(1) != 0) ? FIELD_W'($urandom_range(4094, 4095))
                                               : FIELD_W'($urandom_range(1));
                p.b = ($urandom_range(1) != 0) ? FIELD_W'($urandom_range(4094, 4095))
                                               : FIELD_W'($urandom_range(1));
            end
            2:
            begin
                base = $urandom_range(4095);
                p.r  = FIELD_W'((base + $urandom_range(8) > 4095) ? 4095
                                                                  : base + $urandom_range(8));
                p.g  = FIELD_W'((base + $urandom_range(8) > 4095) ? 4095
                                                                  : base + $urandom_range(8));
                p.b  = FIELD_W'((base + $urandom_range(8) > 4095) ? 4095
                                                                  : base + $urandom_range(8));
            end
            3:
            begin
                m  = $urandom_range(1, 4095);
                lo = $urandom_range(m);
                case ($urandom_range(2))
                    0:       p = '{FIELD_W'(m),  FIELD_W'(m),  FIELD_W'(lo)};
                    1:       p = '{FIELD_W'(lo), FIELD_W'(m),  FIELD_W'(m)};
                    default: p = '{FIELD_W'(m),  FIELD_W'(lo), FIELD_W'(m)};
                endcase
            end
            4:
            begin
                p.r = FIELD_W'($urandom_range(15));
                p.g = FIELD_W'($urandom_range(15));
                p.b = FIELD_W'($urandom_range(15));
            end
            default:
            begin
                p.r = FIELD_W'($urandom);
                p.g = FIELD_W'($urandom);
                p.b = FIELD_W'($urandom);
            end
        endcase
        return p;
    endfunction

    // Offers one pixel and returns at the edge where it transfers. It is
    // always entered at a rising edge. While the sender idles, valid is low
    // and the payload is junk; once valid is raised the payload holds until
    // the transfer. Valid is left high on return so back-to-back pixels keep
    // it high without a glitch.
    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            red         <= FIELD_W'($urandom);
            green       <= FIELD_W'($urandom);
            blue        <= FIELD_W'($urandom);
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= p.r;
        green       <= p.g;
        blue        <= p.b;
        do
            @(posedge clk);
        while (pixel_stall);
        pending_hsv.push_back(predict_hsv(p));
    endtask

    task automatic test_directed_cases();
        pixel_t cases[$];

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // Black, white and mid gray: zero saturation and zero hue.
        cases.push_back('{12'd0,    12'd0,    12'd0});
        cases.push_back('{12'd4095, 12'd4095, 12'd4095});
        cases.push_back('{12'd2048, 12'd2048, 12'd2048});
        // Pure primaries: full chroma, so saturation clamps to all ones.
        cases.push_back('{12'd4095, 12'd0,    12'd0});
        cases.push_back('{12'd0,    12'd4095, 12'd0});
        cases.push_back('{12'd0,    12'd0,    12'd4095});
        // Tied maxima: red beats green, red beats blue, green beats blue.
        cases.push_back('{12'd4095, 12'd4095, 12'd0});
        cases.push_back('{12'd4095, 12'd0,    12'd4095});
        cases.push_back('{12'd0,    12'd4095, 12'd4095});
        cases.push_back('{12'd1000, 12'd1000, 12'd999});
        // Red sector with both signs of the difference; a negative one wraps to under a full turn.
        cases.push_back('{12'd4095, 12'd0,    12'd1});
        cases.push_back('{12'd4095, 12'd1,    12'd0});
        cases.push_back('{12'd2000, 12'd100,  12'd1500});
        // Green and blue sectors with both signs of the difference.
        cases.push_back('{12'd100,  12'd3000, 12'd2000});
        cases.push_back('{12'd2000, 12'd3000, 12'd100});
        cases.push_back('{12'd100,  12'd2000, 12'd3000});
        cases.push_back('{12'd2000, 12'd100,  12'd3000});
        // Smallest nonzero codes and near-gray pixels with a chroma of one.
        cases.push_back('{12'd1,    12'd0,    12'd0});
        cases.push_back('{12'd0,    12'd0,    12'd1});
        cases.push_back('{12'd1,    12'd1,    12'd0});
        cases.push_back('{12'd4095, 12'd4094, 12'd4094});
        cases.push_back('{12'd4094, 12'd4095, 12'd4095});
        cases.push_back('{12'd2730, 12'd2731, 12'd2730});
        foreach (cases[i])
            send_pixel(cases[i]);
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            send_pixel(random_pixel());
    endtask

    // The receiver stops taking results for a long stretch while pixels keep
    // coming, so the pipeline fills and must hold its input back.
    task automatic test_output_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        pixel_valid <= 1'b0;
        hold_go     <= 1'b1;
        @(posedge clk);
        hold_go     <= 1'b0;
        repeat (HOLD_ITEMS)
            send_pixel(random_pixel());
    endtask

    // Counts down the long hold-off, independent of the sender.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
    end

    // The receiver side: random stalls at the phase's rate, plus the hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            hsv_stall <= 1'b0;
        else
            hsv_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Every result transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        hsv_t want;

        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (pending_hsv.size() == 0)
            begin
                report_failure($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                         hue, saturation, value));
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (hue !== want.hue || saturation !== want.sat || value !== want.val)
                    report_failure($sformatf(
                        "hsv mismatch: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
                        want.hue, want.sat, want.val, hue, saturation, value));
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_phase(0, 0);
        test_random_phase(78, 0);
        test_random_phase(0, 78);
        test_random_phase(37, 37);
        test_output_hold_off();

        pixel_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_rgb_to_hsv_converter OK");
        else
            $display("tb_rgb_to_hsv_converter NOT OK");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(WATCHDOG_NS);
        $display("tb_rgb_to_hsv_converter NOT OK");
        $finish;
    end

endmodule
